// File: sv/kvt_pkg.sv
// kvt_pkg: shared widths, operation and status codes, and entry types for the
// key/value table. No dependencies; read by the channel interfaces and the top level.
`default_nettype none

package kvt_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FN_SET = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GET = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  read_value;
    logic [TAG_W-1:0]    read_tag;
  } rsp_t;

endpackage

`default_nettype wire

// File: sv/kvt_req_if.sv
// kvt_req_if: valid/ready channel carrying one request item (operation, key,
// value, tag). Depends on kvt_pkg for field widths.
`default_nettype none

interface kvt_req_if;
  logic                        valid;
  logic                        ready;
  logic [kvt_pkg::FUNC_W-1:0]  func;
  logic [kvt_pkg::KEY_W-1:0]   key;
  logic [kvt_pkg::VALUE_W-1:0] data_value;
  logic [kvt_pkg::TAG_W-1:0]   data_tag;

  modport source (output valid, func, key, data_value, data_tag, input ready);
  modport sink   (input valid, func, key, data_value, data_tag, output ready);
endinterface

`default_nettype wire

// File: sv/kvt_rsp_if.sv
// kvt_rsp_if: valid/ready channel carrying one result item (status, found,
// value, tag). Depends on kvt_pkg for field widths.
`default_nettype none

interface kvt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [kvt_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [kvt_pkg::VALUE_W-1:0]  read_value;
  logic [kvt_pkg::TAG_W-1:0]    read_tag;

  modport source (output valid, status, found, read_value, read_tag, input ready);
  modport sink   (input valid, status, found, read_value, read_tag, output ready);
endinterface

`default_nettype wire

// File: sv/key_value_table_top.sv
// key_value_table_top: fixed-capacity key/value table with in-order linear search.
// Depends on kvt_pkg, kvt_req_if and kvt_rsp_if.
//
// One request item is taken at a time (ready is high only when the table is idle)
// and gives exactly one result item. Entries sit densely in slots 0..count-1 of a
// single-port-read memory; the search reads one slot per cycle and compares its key,
// stopping at the first matching key or after slot count-1; items with a zero key
// or an unused operation skip the search. The result sits in an output register
// until taken.
`default_nettype none

module key_value_table_top #(
  parameter int unsigned CAPACITY = kvt_pkg::DEF_CAPACITY
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  kvt_req_if.sink    req_i,
  kvt_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_MOVE_RD = 3'd2;
  localparam logic [2:0] ST_MOVE_WR = 3'd3;
  localparam logic [2:0] ST_RESP    = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [AW-1:0] cmp_q, cmp_d;
  logic [AW-1:0] slot_q, slot_d;
  logic          rd_vld_q, rd_vld_d;
  logic          out_vld_q, out_vld_d;

  logic [kvt_pkg::FUNC_W-1:0]  func_q, func_d;
  logic [kvt_pkg::KEY_W-1:0]   key_q, key_d;
  logic [kvt_pkg::VALUE_W-1:0] val_q, val_d;
  logic [kvt_pkg::TAG_W-1:0]   tag_q, tag_d;
  kvt_pkg::rsp_t               res_q, res_d;
  kvt_pkg::rsp_t               out_q, out_d;

  kvt_pkg::entry_t mem [CAPACITY];
  kvt_pkg::entry_t rd_data_q;
  kvt_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;

  logic hit;
  logic miss;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  assign hit  = rd_vld_q && (rd_data_q.key == key_q);
  assign miss = (scan_q >= count_q) && !hit;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    scan_d    = scan_q;
    cmp_d     = cmp_q;
    slot_d    = slot_q;
    rd_vld_d  = 1'b0;
    out_vld_d = out_vld_q && !rsp_o.ready;
    func_d    = func_q;
    key_d     = key_q;
    val_d     = val_q;
    tag_d     = tag_q;
    res_d     = res_q;
    out_d     = out_q;
    rd_addr   = scan_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cmp_q;
    wr_data   = '{key: key_q, value: val_q, tag: tag_q};

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          func_d = req_i.func;
          key_d  = req_i.key;
          val_d  = req_i.data_value;
          tag_d  = req_i.data_tag;
          scan_d = '0;
          res_d  = '0;
          if (req_i.func == kvt_pkg::FN_SET && req_i.key == '0) begin
            res_d.status = kvt_pkg::ST_ZERO_KEY;
            state_d      = ST_RESP;
          end else if (req_i.key != '0 && (req_i.func == kvt_pkg::FN_SET ||
                       req_i.func == kvt_pkg::FN_GET || req_i.func == kvt_pkg::FN_DEL)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q < count_q) begin
          rd_vld_d = 1'b1;
          scan_d   = scan_q + CW'(1);
          cmp_d    = scan_q[AW-1:0];
        end
        if (hit) begin
          res_d.found = 1'b1;
          unique case (func_q)
            kvt_pkg::FN_SET: begin
              wr_en   = 1'b1;
              wr_addr = cmp_q;
              state_d = ST_RESP;
            end
            kvt_pkg::FN_GET: begin
              res_d.read_value = rd_data_q.value;
              res_d.read_tag   = rd_data_q.tag;
              state_d          = ST_RESP;
            end
            kvt_pkg::FN_DEL: begin
              slot_d  = cmp_q;
              state_d = ST_MOVE_RD;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end else if (miss) begin
          if (func_q == kvt_pkg::FN_SET) begin
            if (count_q >= CW'(CAPACITY)) begin
              res_d.status = kvt_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[AW-1:0];
              count_d = count_q + CW'(1);
            end
          end
          state_d = ST_RESP;
        end
      end
      ST_MOVE_RD: begin
        // fetch the last live entry to fill the freed slot
        rd_addr = AW'(count_q - CW'(1));
        state_d = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = rd_data_q;
        count_d = count_q - CW'(1);
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    cmp_q  <= cmp_d;
    slot_q <= slot_d;
    func_q <= func_d;
    key_q  <= key_d;
    val_q  <= val_d;
    tag_q  <= tag_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.found      = out_q.found;
  assign rsp_o.read_value = out_q.read_value;
  assign rsp_o.read_tag   = out_q.read_tag;

endmodule

`default_nettype wire
